// ----- rtl/vnea_pkg.sv -----
`timescale 1ns / 1ps
// shared types, codes and helpers for the vertex normal and extent accumulator
// no dependencies

package vnea_pkg;

  localparam int VertsDefault = 1024;
  localparam int QueueDepth   = 2;

  localparam logic signed [31:0] BoxStart = 32'sd2000000000;
  localparam logic signed [15:0] UnitOne  = 16'sd16384;

  typedef enum logic [2:0] {
    KIND_START = 3'd0,
    KIND_ADD   = 3'd1,
    KIND_MARK  = 3'd2,
    KIND_EXT   = 3'd3,
    KIND_RNORM = 3'd4,
    KIND_REXT  = 3'd5
  } kind_e;

  // classified request as it travels through the queue
  typedef struct packed {
    kind_e              kind;
    logic               idx_ok;
    logic [9:0]         vertex_index;
    logic signed [15:0] normal_x;
    logic signed [15:0] normal_y;
    logic signed [15:0] normal_z;
    logic signed [31:0] coord_x;
    logic signed [31:0] coord_y;
    logic signed [31:0] coord_z;
  } item_t;

  typedef struct packed {
    logic clearing;
  } back_stat_t;

  function automatic logic signed [31:0] sat_add32(logic signed [31:0] a,
                                                  logic signed [15:0] b);
    logic signed [32:0] s;
    s = {a[31], a} + {{17{b[15]}}, b};
    if (s[32] != s[31]) begin
      sat_add32 = s[32] ? 32'sh8000_0000 : 32'sh7fff_ffff;
    end else begin
      sat_add32 = s[31:0];
    end
  endfunction

  function automatic logic [31:0] mag32(logic signed [31:0] v);
    mag32 = v[31] ? 32'(-v) : 32'(v);
  endfunction

endpackage

// ----- rtl/vnea_if.sv -----
`timescale 1ns / 1ps
// request and result channels of the accumulator
// no dependencies

interface vnea_req_if;
  logic               valid;
  logic               ready;
  logic [2:0]         kind;
  logic [9:0]         vertex_index;
  logic signed [15:0] normal_x;
  logic signed [15:0] normal_y;
  logic signed [15:0] normal_z;
  logic signed [31:0] coord_x;
  logic signed [31:0] coord_y;
  logic signed [31:0] coord_z;

  modport source (output valid, kind, vertex_index, normal_x, normal_y, normal_z,
                  coord_x, coord_y, coord_z, input ready);
  modport sink (input valid, kind, vertex_index, normal_x, normal_y, normal_z,
                coord_x, coord_y, coord_z, output ready);
endinterface

interface vnea_res_if;
  logic               valid;
  logic               ready;
  logic signed [15:0] unit_x;
  logic signed [15:0] unit_y;
  logic signed [15:0] unit_z;
  logic               zero_length;
  logic signed [31:0] box_max_x;
  logic signed [31:0] box_max_y;
  logic signed [31:0] box_max_z;
  logic signed [31:0] box_min_x;
  logic signed [31:0] box_min_y;
  logic signed [31:0] box_min_z;
  logic [31:0]        bound_radius;

  modport source (output valid, unit_x, unit_y, unit_z, zero_length, box_max_x,
                  box_max_y, box_max_z, box_min_x, box_min_y, box_min_z,
                  bound_radius, input ready);
  modport sink (input valid, unit_x, unit_y, unit_z, zero_length, box_max_x,
                box_max_y, box_max_z, box_min_x, box_min_y, box_min_z,
                bound_radius, output ready);
endinterface

// ----- rtl/vnea_front.sv -----
`timescale 1ns / 1ps
// front end: takes requests, decodes the kind and checks the vertex index
// depends on vnea_pkg, vnea_req_if

module vnea_front import vnea_pkg::*; #(
  parameter int VERTS = VertsDefault
) (
  vnea_req_if.sink   req_i,
  input  logic       full_i,
  input  back_stat_t stat_i,
  output logic       push_o,
  output item_t      item_o
);

  logic known;

  always_comb begin
    unique case (req_i.kind) inside
      KIND_START, KIND_ADD, KIND_MARK, KIND_EXT, KIND_RNORM, KIND_REXT: known = 1'b1;
      default: known = 1'b0;
    endcase
  end

  assign req_i.ready = !full_i && !stat_i.clearing;
  // unknown kinds are taken and dropped
  assign push_o      = req_i.valid && req_i.ready && known;

  always_comb begin
    item_o.kind         = kind_e'(req_i.kind);
    item_o.idx_ok       = ({22'd0, req_i.vertex_index} < 32'(VERTS));
    item_o.vertex_index = req_i.vertex_index;
    item_o.normal_x     = req_i.normal_x;
    item_o.normal_y     = req_i.normal_y;
    item_o.normal_z     = req_i.normal_z;
    item_o.coord_x      = req_i.coord_x;
    item_o.coord_y      = req_i.coord_y;
    item_o.coord_z      = req_i.coord_z;
  end

endmodule

// ----- rtl/vnea_fifo.sv -----
`timescale 1ns / 1ps
// short request queue between front and back
// depends on vnea_pkg

module vnea_fifo import vnea_pkg::*; (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  push_i,
  input  item_t data_i,
  output logic  full_o,
  input  logic  pop_i,
  output logic  empty_o,
  output item_t data_o
);

  localparam int PW = (QueueDepth > 1) ? $clog2(QueueDepth) : 1;

  item_t           mem_q [QueueDepth];
  logic [PW-1:0]   wp_q, rp_q;
  logic [PW:0]     cnt_q;

  assign full_o  = (cnt_q == (PW+1)'(QueueDepth));
  assign empty_o = (cnt_q == '0);
  assign data_o  = mem_q[rp_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q  <= '0;
      rp_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (push_i) begin
        wp_q <= (wp_q == PW'(QueueDepth - 1)) ? '0 : wp_q + 1'b1;
      end
      if (pop_i) begin
        rp_q <= (rp_q == PW'(QueueDepth - 1)) ? '0 : rp_q + 1'b1;
      end
      if (push_i && !pop_i) begin
        cnt_q <= cnt_q + 1'b1;
      end else if (pop_i && !push_i) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wp_q] <= data_i;
    end
  end

endmodule

// ----- rtl/vnea_sqrt.sv -----
`timescale 1ns / 1ps
// iterative integer square root of a 64-bit value, two bits per cycle
// depends on vnea_pkg

module vnea_sqrt import vnea_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  input  logic [63:0] value_i,
  output logic        busy_o,
  output logic        done_o,
  output logic [31:0] root_o
);

  logic        busy_q, done_q;
  logic [63:0] v_q, r_q, bit_q;
  logic [63:0] trial;

  assign trial  = r_q + bit_q;
  assign busy_o = busy_q;
  assign done_o = done_q;
  assign root_o = r_q[31:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      v_q    <= '0;
      r_q    <= '0;
      bit_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        v_q    <= value_i;
        r_q    <= '0;
        bit_q  <= 64'd1 << 62;
      end else if (busy_q) begin
        if (v_q >= trial) begin
          v_q <= v_q - trial;
          r_q <= (r_q >> 1) + bit_q;
        end else begin
          r_q <= r_q >> 1;
        end
        bit_q <= bit_q >> 2;
        if (bit_q == 64'd1) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

endmodule

// ----- rtl/vnea_div.sv -----
`timescale 1ns / 1ps
// three-lane restoring divider for (num * 16384) / den with num <= den
// depends on vnea_pkg

module vnea_div import vnea_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  input  logic [2:0][31:0] num_i,
  input  logic [31:0]      den_i,
  output logic             done_o,
  output logic [2:0][14:0] quo_o
);

  logic             busy_q, done_q;
  logic [3:0]       cnt_q;
  logic [31:0]      den_q;
  logic [2:0][31:0] rem_q;
  logic [2:0][14:0] quo_q;

  assign done_o = done_q;
  assign quo_o  = quo_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    logic [32:0] r2;
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
      den_q  <= '0;
      rem_q  <= '0;
      quo_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
        den_q  <= den_i;
        for (int i = 0; i < 3; i++) begin
          // leading quotient bit: set when num is at least den
          if (num_i[i] >= den_i) begin
            rem_q[i] <= num_i[i] - den_i;
            quo_q[i] <= 15'd1;
          end else begin
            rem_q[i] <= num_i[i];
            quo_q[i] <= 15'd0;
          end
        end
      end else if (busy_q) begin
        for (int i = 0; i < 3; i++) begin
          r2 = {rem_q[i], 1'b0};
          if (r2 >= {1'b0, den_q}) begin
            rem_q[i] <= 32'(r2 - {1'b0, den_q});
            quo_q[i] <= {quo_q[i][13:0], 1'b1};
          end else begin
            rem_q[i] <= r2[31:0];
            quo_q[i] <= {quo_q[i][13:0], 1'b0};
          end
        end
        cnt_q <= cnt_q + 1'b1;
        if (cnt_q == 4'd13) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

endmodule

// ----- rtl/vnea_back.sv -----
`timescale 1ns / 1ps
// back end: vertex store, extents, square and root path, result register
// depends on vnea_pkg, vnea_res_if, vnea_sqrt, vnea_div

module vnea_back import vnea_pkg::*; #(
  parameter int VERTS = VertsDefault
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       filter_en_i,
  input  logic       empty_i,
  input  item_t      item_i,
  output logic       pop_o,
  output back_stat_t stat_o,
  vnea_res_if.source res_o
);

  localparam int AW = $clog2(VERTS);

  typedef enum logic [3:0] {
    S_CLEAR, S_IDLE, S_READ, S_EXEC, S_SQ, S_ROOTGO, S_ROOT, S_DIV, S_OUT
  } state_e;

  typedef struct packed {
    logic               mark;
    logic signed [31:0] sx;
    logic signed [31:0] sy;
    logic signed [31:0] sz;
  } vtx_t;

  state_e             state_q;
  item_t              cur_q;
  logic [AW-1:0]      clr_q;
  vtx_t               mem [VERTS];
  vtx_t               rd_q;
  logic [AW-1:0]      addr;
  logic               mem_we;
  logic [AW-1:0]      mem_wa;
  vtx_t               mem_wd;

  logic signed [2:0][31:0] op_q;
  logic [1:0]         sq_cnt_q;
  logic [31:0]        sq_mag;
  logic [63:0]        prod_q, acc_q;
  logic signed [2:0][31:0] hi_q, lo_q;
  logic [31:0]        far_q;
  logic signed [2:0][15:0] unit_q;
  logic               zl_q;

  logic               sqrt_start, sqrt_busy, sqrt_done;
  logic [31:0]        root;
  logic               div_start, div_done;
  logic [2:0][31:0]   div_num;
  logic [2:0][14:0]   quo;

  assign addr            = AW'(cur_q.vertex_index);
  assign stat_o.clearing = (state_q == S_CLEAR);
  assign pop_o           = (state_q == S_IDLE) && !empty_i;
  assign sqrt_start      = (state_q == S_ROOTGO);
  assign div_start       = (state_q == S_ROOT) && sqrt_done
                           && (cur_q.kind == KIND_RNORM) && (root != '0);

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      div_num[i] = mag32(op_q[i]);
    end
    case (sq_cnt_q)
      2'd0:    sq_mag = mag32(op_q[0]);
      2'd1:    sq_mag = mag32(op_q[1]);
      default: sq_mag = mag32(op_q[2]);
    endcase
  end

  // store write port: clearing sweep or read-modify-write
  always_comb begin
    mem_we = 1'b0;
    mem_wa = addr;
    mem_wd = rd_q;
    if (state_q == S_CLEAR) begin
      mem_we = 1'b1;
      mem_wa = clr_q;
      mem_wd = '0;
    end else if (state_q == S_EXEC) begin
      if (cur_q.kind == KIND_ADD) begin
        mem_we    = 1'b1;
        mem_wd.sx = sat_add32(rd_q.sx, cur_q.normal_x);
        mem_wd.sy = sat_add32(rd_q.sy, cur_q.normal_y);
        mem_wd.sz = sat_add32(rd_q.sz, cur_q.normal_z);
      end else if (cur_q.kind == KIND_MARK) begin
        mem_we      = 1'b1;
        mem_wd.mark = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[mem_wa] <= mem_wd;
    end
    rd_q   <= mem[addr];
    prod_q <= 64'(sq_mag) * 64'(sq_mag);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_CLEAR;
      cur_q    <= '0;
      clr_q    <= '0;
      op_q     <= '0;
      sq_cnt_q <= '0;
      acc_q    <= '0;
      hi_q     <= {3{-BoxStart}};
      lo_q     <= {3{BoxStart}};
      far_q    <= '0;
      unit_q   <= '0;
      zl_q     <= 1'b0;
      res_o.valid        <= 1'b0;
      res_o.unit_x       <= '0;
      res_o.unit_y       <= '0;
      res_o.unit_z       <= '0;
      res_o.zero_length  <= 1'b0;
      res_o.box_max_x    <= '0;
      res_o.box_max_y    <= '0;
      res_o.box_max_z    <= '0;
      res_o.box_min_x    <= '0;
      res_o.box_min_y    <= '0;
      res_o.box_min_z    <= '0;
      res_o.bound_radius <= '0;
    end else begin
      // in S_OUT the valid flag is handled below
      if (res_o.valid && res_o.ready && (state_q != S_OUT)) begin
        res_o.valid <= 1'b0;
      end
      unique case (state_q)
        S_CLEAR: begin
          clr_q <= clr_q + 1'b1;
          if (clr_q == AW'(VERTS - 1)) begin
            state_q <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (!empty_i) begin
            cur_q    <= item_i;
            op_q     <= {item_i.coord_z, item_i.coord_y, item_i.coord_x};
            sq_cnt_q <= '0;
            unique case (item_i.kind)
              KIND_START: begin
                hi_q    <= {3{-BoxStart}};
                lo_q    <= {3{BoxStart}};
                far_q   <= '0;
                clr_q   <= '0;
                state_q <= S_CLEAR;
              end
              KIND_ADD, KIND_MARK, KIND_RNORM: begin
                if (item_i.idx_ok) begin
                  state_q <= S_READ;
                end else if (item_i.kind == KIND_RNORM) begin
                  unit_q  <= {16'sd0, 16'sd0, UnitOne};
                  zl_q    <= 1'b1;
                  state_q <= S_OUT;
                end
              end
              KIND_EXT: begin
                if (!filter_en_i) begin
                  state_q <= S_SQ;
                end else if (item_i.idx_ok) begin
                  state_q <= S_READ;
                end
              end
              KIND_REXT: state_q <= S_OUT;
              default: state_q <= S_IDLE;
            endcase
          end
        end
        S_READ: state_q <= S_EXEC;
        S_EXEC: begin
          unique case (cur_q.kind)
            KIND_EXT:   state_q <= rd_q.mark ? S_SQ : S_IDLE;
            KIND_RNORM: begin
              op_q    <= {rd_q.sz, rd_q.sy, rd_q.sx};
              state_q <= S_SQ;
            end
            default:    state_q <= S_IDLE;
          endcase
        end
        S_SQ: begin
          sq_cnt_q <= sq_cnt_q + 1'b1;
          unique case (sq_cnt_q)
            2'd0: begin
              acc_q <= '0;
              if (cur_q.kind == KIND_EXT) begin
                for (int i = 0; i < 3; i++) begin
                  if ($signed(op_q[i]) > $signed(hi_q[i])) hi_q[i] <= op_q[i];
                  if ($signed(op_q[i]) < $signed(lo_q[i])) lo_q[i] <= op_q[i];
                end
              end
            end
            2'd1: acc_q <= prod_q;
            2'd2: acc_q <= acc_q + prod_q;
            default: begin
              acc_q   <= acc_q + prod_q;
              state_q <= S_ROOTGO;
            end
          endcase
        end
        S_ROOTGO: state_q <= S_ROOT;
        S_ROOT: begin
          if (sqrt_done) begin
            if (cur_q.kind == KIND_EXT) begin
              if (root > far_q) far_q <= root;
              state_q <= S_IDLE;
            end else if (root == '0) begin
              unit_q  <= {16'sd0, 16'sd0, UnitOne};
              zl_q    <= 1'b1;
              state_q <= S_OUT;
            end else begin
              state_q <= S_DIV;
            end
          end
        end
        S_DIV: begin
          if (div_done) begin
            for (int i = 0; i < 3; i++) begin
              unit_q[i] <= op_q[i][31] ? -16'(quo[i]) : 16'(quo[i]);
            end
            zl_q    <= 1'b0;
            state_q <= S_OUT;
          end
        end
        S_OUT: begin
          if (!res_o.valid || res_o.ready) begin
            res_o.valid <= 1'b1;
            if (cur_q.kind == KIND_REXT) begin
              res_o.unit_x       <= '0;
              res_o.unit_y       <= '0;
              res_o.unit_z       <= '0;
              res_o.zero_length  <= 1'b0;
              res_o.box_max_x    <= hi_q[0];
              res_o.box_max_y    <= hi_q[1];
              res_o.box_max_z    <= hi_q[2];
              res_o.box_min_x    <= lo_q[0];
              res_o.box_min_y    <= lo_q[1];
              res_o.box_min_z    <= lo_q[2];
              res_o.bound_radius <= far_q;
            end else begin
              res_o.unit_x       <= unit_q[0];
              res_o.unit_y       <= unit_q[1];
              res_o.unit_z       <= unit_q[2];
              res_o.zero_length  <= zl_q;
              res_o.box_max_x    <= '0;
              res_o.box_max_y    <= '0;
              res_o.box_max_z    <= '0;
              res_o.box_min_x    <= '0;
              res_o.box_min_y    <= '0;
              res_o.box_min_z    <= '0;
              res_o.bound_radius <= '0;
            end
            state_q <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  vnea_sqrt u_sqrt (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (sqrt_start),
    .value_i (acc_q),
    .busy_o  (sqrt_busy),
    .done_o  (sqrt_done),
    .root_o  (root)
  );

  vnea_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .num_i   (div_num),
    .den_i   (root),
    .done_o  (div_done),
    .quo_o   (quo)
  );

`ifndef SYNTH
  a_no_pop_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_CLEAR) |-> !pop_o)
    else $error("queue popped during store clear");
  a_root_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    sqrt_start |-> !sqrt_busy)
    else $error("root started while busy");
  a_div_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_start |-> (cur_q.kind == KIND_RNORM) && (root != '0))
    else $error("division by zero length");
  a_write_ctx: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mem_we |-> (state_q == S_CLEAR) || (state_q == S_EXEC))
    else $error("store written outside clear or update");
`endif

endmodule

// ----- rtl/vertex_normal_and_extent_accumulator.sv -----
`timescale 1ns / 1ps
// top level of the vertex normal and extent accumulator
// depends on vnea_pkg, vnea_if, vnea_front, vnea_fifo, vnea_back

// Sums polygon normals per vertex and returns unit normals (Q1.14) on
// read_normal requests, while tracking the bounding box and the largest
// origin distance of extent_vertex positions. Requests are taken into a
// two-entry queue and carried out one at a time by the back end. After
// reset, and after every start request, the vertex store is swept clear at
// one entry per cycle, during which no request is taken. In the back end,
// add_normal and mark_vertex take a store read and a write, read_extents
// goes straight to the output, extent_vertex takes three serial squares
// then a 32-step square root (after a store read of the mark when
// filtering), and read_normal takes a store read, the squares, the 32-step
// root, a 15-step three-lane divider and the output; the square root unit
// sets the pace. Results sit in an output register, so the queue keeps
// filling while a result waits.

module vertex_normal_and_extent_accumulator import vnea_pkg::*; #(
  parameter int VERTS = VertsDefault
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic        cfg_wdata_i,
  vnea_req_if.sink    req_i,
  vnea_res_if.source  res_o
);

  logic       filter_en_q;  // only marked vertices count toward extents when set
  logic       push, full, pop, empty;
  item_t      push_item, head_item;
  back_stat_t stat;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      filter_en_q <= 1'b0;
    end else if (cfg_we_i) begin
      filter_en_q <= cfg_wdata_i;
    end
  end

  // decode and index check
  vnea_front #(.VERTS(VERTS)) u_front (
    .req_i  (req_i),
    .full_i (full),
    .stat_i (stat),
    .push_o (push),
    .item_o (push_item)
  );

  vnea_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .data_i  (push_item),
    .full_o  (full),
    .pop_i   (pop),
    .empty_o (empty),
    .data_o  (head_item)
  );

  // store, extents, arithmetic and result register
  vnea_back #(.VERTS(VERTS)) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .filter_en_i (filter_en_q),
    .empty_i     (empty),
    .item_i      (head_item),
    .pop_o       (pop),
    .stat_o      (stat),
    .res_o       (res_o)
  );

endmodule
